FILE: rtl/alem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alem_pkg
// Shared types and constants of the affine Lie exponential map core.
// ----------------------------------------------------------------------------
package alem_pkg;

  // One signed fixed-point matrix entry and the top two rows of a matrix,
  // stored row major (index = row * 3 + column).
  typedef logic signed [31:0] q_t;
  typedef q_t mat_t [6];

  // Transform kinds.
  localparam logic [1:0] KIND_ROTATION   = 2'd0;
  localparam logic [1:0] KIND_RIGID      = 2'd1;
  localparam logic [1:0] KIND_SIMILARITY = 2'd2;
  localparam logic [1:0] KIND_AFFINE     = 2'd3;

  // Final sum width and the widths used by the divide-by-24 pipeline.
  localparam int SW  = 40;  // signed Taylor sum
  localparam int XW  = 34;  // (|sum| + 12) / 8
  localparam int HW  = 18;  // high part of x
  localparam int LW  = 16;  // low part of x
  localparam int QHW = 17;  // high part of x / 3
  localparam int YW  = 18;  // remainder * 2^16 + low part
  localparam int QW  = 33;  // full quotient

  // floor(v / 3) = (v * RECIP3) >> RECIP3_SH, exact for v < 2^19.
  localparam logic [18:0] RECIP3    = 19'd349526;
  localparam int          RECIP3_SH = 20;

  // Stage enables of one matrix multiplier.
  typedef struct packed {
    logic mul;
    logic sum;
  } mm_en_t;

  // Stage enables of one divider lane.
  typedef struct packed {
    logic hi;
    logic lo;
    logic fin;
  } dv_en_t;

endpackage

FILE: rtl/affine_lie_exponential_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_lie_exponential_map_core
// Fixed-point truncated Taylor exponential of a 3x3 affine Lie-algebra element.
// ----------------------------------------------------------------------------
// The core takes one beat per cycle while the output side is not stalled and
// returns one beat per input beat, in order, from its registered output stage.
// Each input beat carries six signed fixed-point generator coefficients and a
// transform kind that selects how many of them are active; the core forms A,
// its powers up to A^4 through three two-stage matrix multipliers, sums
// 24*(I + A) + 12*A^2 + 4*A^3 + A^4 and divides by 24 in a three-stage unit built
// on constant reciprocal multiplies. Every pipeline stage has its own valid bit
// and its own load enable, so bubbles close up while the output is stalled and
// a new beat is accepted whenever any stage ahead has room. The overflow flag
// reports saturation anywhere along the datapath.
module affine_lie_exponential_map_core import alem_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rotation, shift u, shift v, scale, stretch, shear coefficients, 32 bits each
  input  logic [191:0] s_axis_tdata,
  // transform_kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00, m01, m02, m10, m11, m12, 32 bits each
  output logic [191:0] m_axis_tdata,
  // overflow
  output logic [0:0]   m_axis_tuser
);

  localparam int NS = 11;

  // Stage valid bits and load enables; a stage loads when it is empty or
  // the stage after it loads too.
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  // Stage 0: mask inactive coefficients and form A.
  q_t                 coef [6];
  logic signed [32:0] e    [6];
  mat_t               a_d;
  logic               a_sat_d;
  mat_t               a_q;
  logic               a_sat_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      coef[k] = q_t'(s_axis_tdata[32*k +: 32]);
    end
    if (s_axis_tuser == KIND_ROTATION) begin
      coef[1] = '0;
      coef[2] = '0;
    end
    if (s_axis_tuser == KIND_ROTATION || s_axis_tuser == KIND_RIGID) begin
      coef[3] = '0;
    end
    if (s_axis_tuser != KIND_AFFINE) begin
      coef[4] = '0;
      coef[5] = '0;
    end
    e[0] = 33'(coef[3]) + 33'(coef[4]);
    e[1] = 33'(coef[5]) - 33'(coef[0]);
    e[2] = 33'(coef[1]);
    e[3] = 33'(coef[0]) + 33'(coef[5]);
    e[4] = 33'(coef[3]) - 33'(coef[4]);
    e[5] = 33'(coef[2]);
    a_sat_d = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (e[k][32] != e[k][31]) begin
        a_d[k]  = e[k][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        a_sat_d = 1'b1;
      end else begin
        a_d[k] = q_t'(e[k][31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q     <= a_d;
      a_sat_q <= a_sat_d;
    end
  end

  // Delay lines that keep A, A^2 and A^3 aligned with later stages.
  mat_t a_dq  [6];
  mat_t p2_dq [4];
  mat_t p3_dq [2];
  mat_t p2, p3, p4;
  logic sat2, sat3, sat4;

  always_ff @(posedge clk_i) begin
    if (en[1]) a_dq[0] <= a_q;
    for (int k = 1; k < 6; k++) begin
      if (en[k+1]) a_dq[k] <= a_dq[k-1];
    end
    if (en[3]) p2_dq[0] <= p2;
    for (int k = 1; k < 4; k++) begin
      if (en[k+3]) p2_dq[k] <= p2_dq[k-1];
    end
    if (en[5]) p3_dq[0] <= p3;
    if (en[6]) p3_dq[1] <= p3_dq[0];
  end

  // Stages 1 to 6: the three powers.
  alem_matmul #(.FRAC_BITS(FRAC_BITS)) u_pow2 (
    .clk_i (clk_i),
    .en_i  ('{mul: en[1], sum: en[2]}),
    .x_i   (a_q),
    .y_i   (a_q),
    .sat_i (a_sat_q),
    .z_o   (p2),
    .sat_o (sat2)
  );

  alem_matmul #(.FRAC_BITS(FRAC_BITS)) u_pow3 (
    .clk_i (clk_i),
    .en_i  ('{mul: en[3], sum: en[4]}),
    .x_i   (p2),
    .y_i   (a_dq[1]),
    .sat_i (sat2),
    .z_o   (p3),
    .sat_o (sat3)
  );

  alem_matmul #(.FRAC_BITS(FRAC_BITS)) u_pow4 (
    .clk_i (clk_i),
    .en_i  ('{mul: en[5], sum: en[6]}),
    .x_i   (p3),
    .y_i   (a_dq[3]),
    .sat_i (sat3),
    .z_o   (p4),
    .sat_o (sat4)
  );

  // Stage 7: 24*(I + A) + 12*A^2 + 4*A^3 + A^4, then sign and (|sum| + 12) / 8.
  logic [XW-1:0] x_d [6];
  logic [XW-1:0] x_q [6];
  logic [5:0]    neg_d;
  logic [5:0]    neg_q;
  logic          sat7_q;
  logic          sat10_q;
  logic          sat10_mid_q;
  logic          sat10_pre_q;

  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] s;
    logic        [SW-1:0] mag;
    logic        [SW-1:0] xw;
    for (int k = 0; k < 6; k++) begin
      t = SW'(a_dq[5][k]);
      if (k == 0 || k == 4) t = t + (SW'(1) << FRAC_BITS);
      s = (t <<< 4) + (t <<< 3)
        + (SW'(p2_dq[3][k]) <<< 3) + (SW'(p2_dq[3][k]) <<< 2)
        + (SW'(p3_dq[1][k]) <<< 2) + SW'(p4[k]);
      neg_d[k] = s[SW-1];
      mag      = neg_d[k] ? SW'(-s) : SW'(s);
      xw       = (mag + SW'(12)) >> 3;
      x_d[k]   = xw[XW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      x_q    <= x_d;
      neg_q  <= neg_d;
      sat7_q <= sat4;
    end
    if (en[8])  sat10_pre_q <= sat7_q;
    if (en[9])  sat10_mid_q <= sat10_pre_q;
    if (en[10]) sat10_q     <= sat10_mid_q;
  end

  // Stages 8 to 10: divide each entry by 24; the last stage is the output.
  q_t         m_val [6];
  logic [5:0] m_sat;

  for (genvar g = 0; g < 6; g++) begin : g_div
    alem_div24 u_div (
      .clk_i (clk_i),
      .en_i  ('{hi: en[8], lo: en[9], fin: en[10]}),
      .x_i   (x_q[g]),
      .neg_i (neg_q[g]),
      .val_o (m_val[g]),
      .sat_o (m_sat[g])
    );
    assign m_axis_tdata[32*g +: 32] = m_val[g];
  end

  assign m_axis_tuser[0] = sat10_q || (|m_sat);

  // Stage 5, when it holds a beat and cannot move, keeps it.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] && !en[5] |=> v_q[5])
    else $error("pipeline stage dropped a stalled beat");

  // With the output register empty the whole pipeline can move.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // An accepted beat occupies the first stage on the next edge.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted beat not captured");

endmodule

FILE: rtl/alem_matmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alem_matmul
// Two-stage fixed-point product of two matrices with a zero bottom row.
// ----------------------------------------------------------------------------
module alem_matmul import alem_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk_i,
  input  mm_en_t en_i,
  input  mat_t   x_i,
  input  mat_t   y_i,
  input  logic   sat_i,
  output mat_t   z_o,
  output logic   sat_o
);

  localparam logic [65:0] HALF = 66'(1) << (FRAC_BITS - 1);

  logic signed [63:0] prod_d [12];
  logic signed [63:0] prod_q [12];
  logic               sat_mid_q;
  mat_t               z_d;
  mat_t               z_q;
  logic               sat_d;
  logic               sat_q;

  // First stage: the twelve partial products.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[2*(i*3+j)]   = 64'(x_i[i*3])   * 64'(y_i[j]);
        prod_d[2*(i*3+j)+1] = 64'(x_i[i*3+1]) * 64'(y_i[3+j]);
      end
    end
  end

  // Second stage: add, round half away from zero, saturate.
  // The 65-bit sum never wraps, so no separate 64-bit clamp is needed.
  always_comb begin
    logic signed [64:0] sum;
    logic        [64:0] mag;
    logic        [65:0] rnd;
    logic        [65:0] q;
    logic               neg;
    sat_d = sat_mid_q;
    for (int k = 0; k < 6; k++) begin
      sum = 65'(prod_q[2*k]) + 65'(prod_q[2*k+1]);
      neg = sum[64];
      mag = neg ? 65'(-sum) : 65'(sum);
      rnd = {1'b0, mag} + HALF;
      q   = rnd >> FRAC_BITS;
      if (!neg && q > 66'h7FFF_FFFF) begin
        z_d[k] = 32'sh7FFF_FFFF;
        sat_d  = 1'b1;
      end else if (neg && q > 66'h8000_0000) begin
        z_d[k] = 32'sh8000_0000;
        sat_d  = 1'b1;
      end else begin
        z_d[k] = neg ? q_t'(~q[31:0] + 32'd1) : q_t'(q[31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q    <= prod_d;
      sat_mid_q <= sat_i;
    end
    if (en_i.sum) begin
      z_q   <= z_d;
      sat_q <= sat_d;
    end
  end

  assign z_o   = z_q;
  assign sat_o = sat_q;

endmodule

FILE: rtl/alem_div24.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alem_div24
// Three-stage divide of a sign and magnitude by 24 with saturation.
// ----------------------------------------------------------------------------
module alem_div24 import alem_pkg::*; (
  input  logic          clk_i,
  input  dv_en_t        en_i,
  input  logic [XW-1:0] x_i,    // (|sum| + 12) / 8, still to be divided by 3
  input  logic          neg_i,
  output q_t            val_o,
  output logic          sat_o
);

  logic [QHW-1:0] qh_d, qh_q;
  logic [YW-1:0]  y_d, y_q;
  logic           neg_q, neg2_q;
  logic [QW-1:0]  q_d, q_q;
  q_t             val_d, val_q;
  logic           sat_d, sat_q;

  // High part first: h = 3*qh + rh, then y = rh * 2^16 + low part.
  always_comb begin
    logic [HW+18:0] ph;
    logic [1:0]     rh;
    ph   = (HW+19)'(x_i[XW-1:LW]) * (HW+19)'(RECIP3);
    qh_d = ph[RECIP3_SH +: QHW];
    rh   = 2'(x_i[XW-1:LW] - ((HW)'(qh_d) << 1) - HW'(qh_d));
    y_d  = {rh, x_i[LW-1:0]};
  end

  always_comb begin
    logic [YW+18:0] py;
    py  = (YW+19)'(y_q) * (YW+19)'(RECIP3);
    q_d = {qh_q, py[RECIP3_SH +: LW]};
  end

  always_comb begin
    sat_d = 1'b0;
    if (!neg2_q && q_q > 33'h0_7FFF_FFFF) begin
      val_d = 32'sh7FFF_FFFF;
      sat_d = 1'b1;
    end else if (neg2_q && q_q > 33'h0_8000_0000) begin
      val_d = 32'sh8000_0000;
      sat_d = 1'b1;
    end else begin
      val_d = neg2_q ? q_t'(~q_q[31:0] + 32'd1) : q_t'(q_q[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.hi) begin
      qh_q  <= qh_d;
      y_q   <= y_d;
      neg_q <= neg_i;
    end
    if (en_i.lo) begin
      q_q    <= q_d;
      neg2_q <= neg_q;
    end
    if (en_i.fin) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule
